// ===== rtl/stt_pkg.sv =====
// Shared token codes, queue status and character helpers for the tokenizer.
package stt_pkg;

   typedef enum logic [3:0] {
      TK_END       = 4'd0,
      TK_ASSIGN    = 4'd1,
      TK_PLUS      = 4'd2,
      TK_MINUS     = 4'd3,
      TK_STAR      = 4'd4,
      TK_SLASH     = 4'd5,
      TK_SEMI      = 4'd6,
      TK_LPAREN    = 4'd7,
      TK_RPAREN    = 4'd8,
      TK_INT_LIT   = 4'd9,
      TK_DBL_LIT   = 4'd10,
      TK_KW_INT    = 4'd11,
      TK_KW_DOUBLE = 4'd12,
      TK_KW_PRINT  = 4'd13,
      TK_IDENT     = 4'd14,
      TK_ERROR     = 4'd15
   } token_kind_type;

   localparam int unsigned KIND_BITS = 4;

   typedef struct packed {
      logic full;
      logic empty;
   } stt_qstat_type;

   function automatic token_kind_type op_kind(input logic [7:0] c);
      token_kind_type k;
      case (c)
         8'h3D:   k = TK_ASSIGN;
         8'h2B:   k = TK_PLUS;
         8'h2D:   k = TK_MINUS;
         8'h2A:   k = TK_STAR;
         8'h2F:   k = TK_SLASH;
         8'h3B:   k = TK_SEMI;
         8'h28:   k = TK_LPAREN;
         8'h29:   k = TK_RPAREN;
         default: k = TK_ERROR;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/stt_if.sv =====
// Valid/ready channel interfaces for the byte input and the token output.
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_input;

   modport source (output valid, output ch, output end_of_input, input ready);
   modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface stt_rsp_if #(
   parameter int POS_BITS = 32,
   parameter int LEN_BITS = 16
);
   logic                valid;
   logic                ready;
   logic [3:0]          token_kind;
   logic [POS_BITS-1:0] start_pos;
   logic [LEN_BITS-1:0] token_len;
   logic                last;

   modport source (output valid, output token_kind, output start_pos, output token_len,
                   output last, input ready);
   modport sink   (input valid, input token_kind, input start_pos, input token_len,
                   input last, output ready);
endinterface

// ===== rtl/stt_front.sv =====
// Front end: byte classification, token state and per-byte token records.
module stt_front #(
   parameter int POS_BITS   = 32,
   parameter int LEN_BITS   = 16,
   parameter int ENTRY_BITS = 1 + 2 * (4 + POS_BITS + LEN_BITS)
) (
   input  logic                    clock,
   input  logic                    reset,
   stt_req_if.sink                 req,
   input  stt_pkg::stt_qstat_type  qstat,
   output logic                    push,
   output logic [ENTRY_BITS-1:0]   entry
);
   import stt_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER
   } mode_type;

   localparam logic [1:0] KW_NONE   = 2'd0;
   localparam logic [1:0] KW_INT    = 2'd1;
   localparam logic [1:0] KW_DOUBLE = 2'd2;
   localparam logic [1:0] KW_PRINT  = 2'd3;

   function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] idx);
      logic [7:0] r;
      r = 8'h00;
      case (kw)
         KW_INT: begin
            case (idx)
               3'd0:    r = "i";
               3'd1:    r = "n";
               3'd2:    r = "t";
               default: r = 8'h00;
            endcase
         end
         KW_DOUBLE: begin
            case (idx)
               3'd0:    r = "d";
               3'd1:    r = "o";
               3'd2:    r = "u";
               3'd3:    r = "b";
               3'd4:    r = "l";
               3'd5:    r = "e";
               default: r = 8'h00;
            endcase
         end
         KW_PRINT: begin
            case (idx)
               3'd0:    r = "p";
               3'd1:    r = "r";
               3'd2:    r = "i";
               3'd3:    r = "n";
               3'd4:    r = "t";
               default: r = 8'h00;
            endcase
         end
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] kw_len(input logic [1:0] kw);
      logic [2:0] r;
      case (kw)
         KW_INT:    r = 3'd3;
         KW_DOUBLE: r = 3'd6;
         KW_PRINT:  r = 3'd5;
         default:   r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic token_kind_type kw_kind(input logic [1:0] kw);
      token_kind_type r;
      case (kw)
         KW_INT:    r = TK_KW_INT;
         KW_DOUBLE: r = TK_KW_DOUBLE;
         KW_PRINT:  r = TK_KW_PRINT;
         default:   r = TK_IDENT;
      endcase
      return r;
   endfunction

   localparam int TOK_BITS = KIND_BITS + POS_BITS + LEN_BITS;

   mode_type            mode_ff, mode_in;
   logic                dot_ff, dot_in;
   logic [1:0]          kw_ff, kw_in;
   logic [POS_BITS-1:0] start_ff, start_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic                done_ff, done_in;

   logic [7:0]          c;
   logic                eoi, accept, work;
   logic                is_alpha, is_digit, is_space, is_us, is_dot;
   logic                id_ext, num_ext, extend;
   logic [LEN_BITS-1:0] len_grow;
   logic                kw_keep;
   logic                flush_valid, second_valid;
   token_kind_type      flush_kind, second_kind;
   logic [LEN_BITS-1:0] second_len;
   logic [TOK_BITS-1:0] flush_tok, second_tok, tok0;

   assign c   = req.ch;
   assign eoi = req.end_of_input;

   assign req.ready = !qstat.full;
   assign accept    = req.valid && req.ready;
   assign work      = accept && !done_ff;

   always_comb begin
      is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      is_digit = (c >= "0" && c <= "9");
      is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
      is_us    = (c == "_");
      is_dot   = (c == ".");

      id_ext  = (mode_ff == MODE_IDENT) && (is_alpha || is_digit || is_us);
      num_ext = (mode_ff == MODE_NUMBER) && (is_digit || (is_dot && !dot_ff));
      extend  = !eoi && (id_ext || num_ext);

      // hold at all ones once saturated
      len_grow = (&len_ff) ? len_ff : len_ff + 1'b1;
      // keep the keyword only while the byte matches its next character
      kw_keep  = (kw_ff != KW_NONE) && ((len_ff >> 3) == '0)
                 && (kw_char(kw_ff, len_ff[2:0]) == c);

      flush_valid = (mode_ff != MODE_IDLE) && !extend;
      if (mode_ff == MODE_IDENT) begin
         if (kw_ff != KW_NONE && len_ff == LEN_BITS'(kw_len(kw_ff)))
            flush_kind = kw_kind(kw_ff);
         else
            flush_kind = TK_IDENT;
      end else begin
         flush_kind = dot_ff ? TK_DBL_LIT : TK_INT_LIT;
      end

      if (eoi) begin
         second_valid = 1'b1;
         second_kind  = TK_END;
         second_len   = '0;
      end else begin
         second_valid = !extend && !is_space && !is_alpha && !is_us && !is_digit;
         second_kind  = op_kind(c);
         second_len   = LEN_BITS'(1);
      end

      flush_tok  = {flush_kind, start_ff, len_ff};
      second_tok = {second_kind, pos_ff, second_len};
      tok0       = flush_valid ? flush_tok : second_tok;
      entry      = {flush_valid && second_valid, tok0, second_tok};
      push       = work && (flush_valid || second_valid);
   end

   always_comb begin
      mode_in  = mode_ff;
      dot_in   = dot_ff;
      kw_in    = kw_ff;
      start_in = start_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      done_in  = done_ff;
      if (work) begin
         if (eoi) begin
            done_in = 1'b1;
            mode_in = MODE_IDLE;
            dot_in  = 1'b0;
            kw_in   = KW_NONE;
            len_in  = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (id_ext) begin
               kw_in  = kw_keep ? kw_ff : KW_NONE;
               len_in = len_grow;
            end else if (num_ext) begin
               dot_in = dot_ff || is_dot;
               len_in = len_grow;
            end else begin
               mode_in = MODE_IDLE;
               dot_in  = 1'b0;
               kw_in   = KW_NONE;
               len_in  = '0;
               if (is_alpha || is_us) begin
                  mode_in  = MODE_IDENT;
                  start_in = pos_ff;
                  len_in   = LEN_BITS'(1);
                  kw_in    = (c == "i") ? KW_INT : (c == "d") ? KW_DOUBLE :
                             (c == "p") ? KW_PRINT : KW_NONE;
               end else if (is_digit) begin
                  mode_in  = MODE_NUMBER;
                  start_in = pos_ff;
                  len_in   = LEN_BITS'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         dot_ff   <= 1'b0;
         kw_ff    <= KW_NONE;
         start_ff <= '0;
         len_ff   <= '0;
         pos_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         dot_ff   <= dot_in;
         kw_ff    <= kw_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         done_ff  <= done_in;
      end
   end

endmodule

// ===== rtl/stt_queue.sv =====
// Four-entry queue of token records between the front and back ends.
module stt_queue #(
   parameter int WIDTH = 105
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        head,
   output stt_pkg::stt_qstat_type  qstat
);
   import stt_pkg::*;

   localparam int DEPTH     = 4;
   localparam int ADDR_BITS = $clog2(DEPTH);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [ADDR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ADDR_BITS:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   always_comb begin
      qstat.full  = (count_ff == (ADDR_BITS+1)'(DEPTH));
      qstat.empty = (count_ff == '0);
      do_push     = push && !qstat.full;
      do_pop      = pop && !qstat.empty;
      wr_ptr_in   = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in   = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in    = count_ff + (ADDR_BITS+1)'(do_push) - (ADDR_BITS+1)'(do_pop);
      head        = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/stt_back.sv =====
// Back end: sends each queued record out as one or two token beats.
module stt_back #(
   parameter int POS_BITS   = 32,
   parameter int LEN_BITS   = 16,
   parameter int ENTRY_BITS = 1 + 2 * (4 + POS_BITS + LEN_BITS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  stt_pkg::stt_qstat_type  qstat,
   input  logic [ENTRY_BITS-1:0]   head,
   output logic                    pop,
   stt_rsp_if.source               rsp
);
   import stt_pkg::*;

   localparam int TOK_BITS = KIND_BITS + POS_BITS + LEN_BITS;

   logic                second_ff, second_in;
   logic                two;
   logic [TOK_BITS-1:0] tok;
   logic                beat;

   always_comb begin
      two = head[ENTRY_BITS-1];
      tok = second_ff ? head[TOK_BITS-1:0] : head[2*TOK_BITS-1:TOK_BITS];

      rsp.valid      = !qstat.empty;
      rsp.token_kind = tok[TOK_BITS-1 -: KIND_BITS];
      rsp.start_pos  = tok[LEN_BITS +: POS_BITS];
      rsp.token_len  = tok[LEN_BITS-1:0];
      rsp.last       = second_ff || !two;

      beat = rsp.valid && rsp.ready;
      // drop the record once its final beat has gone
      pop  = beat && rsp.last;
      if (beat)
         second_in = !rsp.last;
      else
         second_in = second_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// A byte's token record is registered in the queue before its first token beat reaches the output.
// One byte per cycle is taken while the queue is not full; a byte that yields two tokens
// is sent as two token beats, and the four-record queue absorbs the difference.
// Bytes and end markers after the end token are taken and dropped.
// Reset is synchronous: it clears the scan state, the byte offset and the queue.
module source_text_tokenizer #(
   parameter int POS_BITS = 32,
   parameter int LEN_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   stt_req_if.sink     req_bus,
   stt_rsp_if.source   rsp_bus
);
   import stt_pkg::*;

   localparam int ENTRY_BITS = 1 + 2 * (KIND_BITS + POS_BITS + LEN_BITS);

   stt_qstat_type         qstat;
   logic                  push, pop;
   logic [ENTRY_BITS-1:0] entry, head;

   stt_front #(
      .POS_BITS   (POS_BITS),
      .LEN_BITS   (LEN_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .qstat (qstat),
      .push  (push),
      .entry (entry)
   );

   stt_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   stt_back #(
      .POS_BITS   (POS_BITS),
      .LEN_BITS   (LEN_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .qstat (qstat),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_bus)
   );

endmodule

// ===== rtl/stt_checker.sv =====
// Port-level checks on the token output, bound to the tokenizer top level.
module stt_checker #(
   parameter int POS_BITS = 32,
   parameter int LEN_BITS = 16
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [3:0]          rsp_token_kind,
   input logic [POS_BITS-1:0] rsp_start_pos,
   input logic [LEN_BITS-1:0] rsp_token_len,
   input logic                rsp_last
);
   import stt_pkg::*;

   logic ended_ff, ended_in;

   assign ended_in = ended_ff || (rsp_valid && rsp_ready && rsp_token_kind == TK_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         ended_ff <= 1'b0;
      end else begin
         ended_ff <= ended_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_start_pos) && $stable(rsp_token_len) && $stable(rsp_last))
      else $error("token beat changed while stalled");

   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == TK_END |-> rsp_last && rsp_token_len == '0)
      else $error("end token not last or not empty");

   a_single_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_token_kind >= TK_ASSIGN && rsp_token_kind <= TK_RPAREN)
         || rsp_token_kind == TK_ERROR) |-> rsp_token_len == LEN_BITS'(1))
      else $error("single-character token with length other than one");

   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      ended_ff |-> !rsp_valid)
      else $error("token beat after the end token");

endmodule

bind source_text_tokenizer stt_checker #(
   .POS_BITS (POS_BITS),
   .LEN_BITS (LEN_BITS)
) u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_token_kind (rsp_bus.token_kind),
   .rsp_start_pos  (rsp_bus.start_pos),
   .rsp_token_len  (rsp_bus.token_len),
   .rsp_last       (rsp_bus.last)
);
